// ===== design/cmet_pkg.sv =====
`default_nettype none

package cmet_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned COUNT_W = 7;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic valid;
    logic done;
  } ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] zr;
    logic signed [DATA_W-1:0] zi;
    logic signed [DATA_W-1:0] cr;
    logic signed [DATA_W-1:0] ci;
  } point_t;

endpackage

`default_nettype wire

// ===== design/cmet_in_if.sv =====
`default_nettype none

interface cmet_in_if;
  import cmet_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] c_real;
  logic signed [DATA_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

`default_nettype wire

// ===== design/cmet_out_if.sv =====
`default_nettype none

interface cmet_out_if;
  import cmet_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink (input valid, input iteration_count, output ready);
endinterface

`default_nettype wire

// ===== design/cmet_cfg_if.sv =====
`default_nettype none

interface cmet_cfg_if;
  import cmet_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] max_iterations;

  modport source (output valid, output max_iterations, input ready);
  modport sink (input valid, input max_iterations, output ready);
endinterface

`default_nettype wire

// ===== design/cmet_iter.sv =====
`default_nettype none

module cmet_iter #(
  parameter int unsigned FRAC_BITS = 26,
  parameter int unsigned CNT_W     = 7,
  parameter int unsigned ITER_IDX  = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [cmet_pkg::CFG_W-1:0]  limit_i,
  input  cmet_pkg::ctl_t              ctl_i,
  input  cmet_pkg::point_t            pt_i,
  input  logic [CNT_W-1:0]            count_i,
  output cmet_pkg::ctl_t              ctl_o,
  output cmet_pkg::point_t            pt_o,
  output logic [CNT_W-1:0]            count_o
);
  import cmet_pkg::*;

  localparam int unsigned SQ_W   = 2 * DATA_W;
  localparam int unsigned DIFF_W = SQ_W + 1;
  localparam int unsigned PP_W   = DATA_W + DATA_W + 1;
  localparam int unsigned PROD_W = DATA_W + DIFF_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned SH     = 2 * FRAC_BITS;
  localparam int unsigned ESC_SH = 2 * FRAC_BITS + 2;
  localparam logic [31:0] IDX    = 32'(ITER_IDX);

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(DATA_MAX);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(DATA_MIN);

  function automatic logic signed [DATA_W-1:0] scale_sat(
    input logic signed [PROD_W-1:0] p,
    input logic signed [DATA_W-1:0] c
  );
    logic signed [SUM_W-1:0] v;
    v = SUM_W'(p >>> SH) + SUM_W'(c);
    if (v > SAT_MAX) begin
      return DATA_MAX;
    end else if (v < SAT_MIN) begin
      return DATA_MIN;
    end
    return $signed(v[DATA_W-1:0]);
  endfunction

  // stage 0: squares
  logic                     v0_q, done0_q;
  logic [CNT_W-1:0]         cnt0_q;
  point_t                   pt0_q;
  logic signed [SQ_W-1:0]   a0_d, b0_d, a0_q, b0_q;

  // stage 1: escape test and cubic factors
  logic                     v1_q, done1_q, done1_d;
  logic [CNT_W-1:0]         cnt1_q, cnt1_d;
  point_t                   pt1_q;
  logic signed [DIFF_W-1:0] dr1_d, di1_d, dr1_q, di1_q;
  logic [SQ_W-1:0]          mag;
  logic                     esc, active;

  // stage 2: partial products
  logic                     v2_q, done2_q;
  logic [CNT_W-1:0]         cnt2_q;
  point_t                   pt2_q;
  logic signed [PP_W-1:0]   rlo2_d, rhi2_d, ilo2_d, ihi2_d;
  logic signed [PP_W-1:0]   rlo2_q, rhi2_q, ilo2_q, ihi2_q;

  // stage 3: full products
  logic                     v3_q, done3_q;
  logic [CNT_W-1:0]         cnt3_q;
  point_t                   pt3_q;
  logic signed [PROD_W-1:0] pr3_d, pi3_d, pr3_q, pi3_q;

  // stage 4: rescale, add c, saturate
  logic                     v4_q, done4_q;
  logic [CNT_W-1:0]         cnt4_q;
  point_t                   pt4_d, pt4_q;

  assign a0_d = pt_i.zr * pt_i.zr;
  assign b0_d = pt_i.zi * pt_i.zi;

  assign mag    = SQ_W'(a0_q) + SQ_W'(b0_q);
  assign esc    = (mag >> ESC_SH) != '0;
  assign active = !done0_q && (IDX < 32'(limit_i));

  always_comb begin
    done1_d = done0_q || !active || esc;
    cnt1_d  = (active && !esc) ? cnt0_q + CNT_W'(1'b1) : cnt0_q;
    dr1_d   = DIFF_W'(a0_q) - ((DIFF_W'(b0_q) <<< 1) + DIFF_W'(b0_q));
    di1_d   = ((DIFF_W'(a0_q) <<< 1) + DIFF_W'(a0_q)) - DIFF_W'(b0_q);
  end

  assign rlo2_d = pt1_q.zr * $signed({1'b0, dr1_q[DATA_W-1:0]});
  assign rhi2_d = pt1_q.zr * $signed(dr1_q[DIFF_W-1:DATA_W]);
  assign ilo2_d = pt1_q.zi * $signed({1'b0, di1_q[DATA_W-1:0]});
  assign ihi2_d = pt1_q.zi * $signed(di1_q[DIFF_W-1:DATA_W]);

  assign pr3_d = (PROD_W'(rhi2_q) <<< DATA_W) + PROD_W'(rlo2_q);
  assign pi3_d = (PROD_W'(ihi2_q) <<< DATA_W) + PROD_W'(ilo2_q);

  always_comb begin
    pt4_d    = pt3_q;
    pt4_d.zr = scale_sat(pr3_q, pt3_q.cr);
    pt4_d.zi = scale_sat(pi3_q, pt3_q.ci);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= ctl_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      done0_q <= ctl_i.done;
      cnt0_q  <= count_i;
      pt0_q   <= pt_i;
      a0_q    <= a0_d;
      b0_q    <= b0_d;

      done1_q <= done1_d;
      cnt1_q  <= cnt1_d;
      pt1_q   <= pt0_q;
      dr1_q   <= dr1_d;
      di1_q   <= di1_d;

      done2_q <= done1_q;
      cnt2_q  <= cnt1_q;
      pt2_q   <= pt1_q;
      rlo2_q  <= rlo2_d;
      rhi2_q  <= rhi2_d;
      ilo2_q  <= ilo2_d;
      ihi2_q  <= ihi2_d;

      done3_q <= done2_q;
      cnt3_q  <= cnt2_q;
      pt3_q   <= pt2_q;
      pr3_q   <= pr3_d;
      pi3_q   <= pi3_d;

      done4_q <= done3_q;
      cnt4_q  <= cnt3_q;
      pt4_q   <= pt4_d;
    end
  end

  assign ctl_o   = '{valid: v4_q, done: done4_q};
  assign pt_o    = pt4_q;
  assign count_o = cnt4_q;

endmodule

`default_nettype wire

// ===== design/cubic_multibrot_escape_time.sv =====
// cubic multibrot escape-time counter, z -> z^3 + c starting at z = c
// in_i carries one point (c_real, c_imag, signed fixed point with FRAC_BITS
// fraction bits) per transaction; out_o returns one iteration_count per
// point, in the order the points came in
// cfg_i writes max_iterations (limit, clamped to ITER_BOUND); it is always
// ready and should only be written while no point is in flight
// the datapath is a chain of ITER_BOUND iteration units, each five register
// stages deep (squares, escape test, partial products, product sum, rescale
// with saturation), so latency is 5 * ITER_BOUND cycles (320 by default)
// throughput is one point per cycle; escaped points keep flowing with a
// done flag so every point sees the same latency
// when out_o is stalled with a result waiting, the whole chain holds and
// in_i.ready drops; nothing is dropped or duplicated
// reset clears all stage valid bits and sets max_iterations to 64
`default_nettype none

module cubic_multibrot_escape_time #(
  parameter int unsigned ITER_BOUND = 64,
  parameter int unsigned FRAC_BITS  = 26
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmet_cfg_if.sink    cfg_i,
  cmet_in_if.sink     in_i,
  cmet_out_if.source  out_o
);
  import cmet_pkg::*;

  localparam int unsigned CNT_W = $clog2(ITER_BOUND + 1);

  logic [CFG_W-1:0] limit_q;
  logic             en;

  ctl_t             ctl_c [0:ITER_BOUND];
  point_t           pt_c  [0:ITER_BOUND];
  logic [CNT_W-1:0] cnt_c [0:ITER_BOUND];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.max_iterations;
    end
  end

  assign en         = !ctl_c[ITER_BOUND].valid || out_o.ready;
  assign in_i.ready = en;

  assign ctl_c[0] = '{valid: in_i.valid, done: 1'b0};
  assign pt_c[0]  = '{zr: in_i.c_real, zi: in_i.c_imag, cr: in_i.c_real, ci: in_i.c_imag};
  assign cnt_c[0] = '0;

  for (genvar k = 0; k < ITER_BOUND; k++) begin : g_iter
    cmet_iter #(
      .FRAC_BITS (FRAC_BITS),
      .CNT_W     (CNT_W),
      .ITER_IDX  (k)
    ) u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .limit_i (limit_q),
      .ctl_i   (ctl_c[k]),
      .pt_i    (pt_c[k]),
      .count_i (cnt_c[k]),
      .ctl_o   (ctl_c[k+1]),
      .pt_o    (pt_c[k+1]),
      .count_o (cnt_c[k+1])
    );
  end

  assign out_o.valid           = ctl_c[ITER_BOUND].valid;
  assign out_o.iteration_count = COUNT_W'(cnt_c[ITER_BOUND]);

endmodule

`default_nettype wire
